// ===== sv/smm_pkg.sv =====
`timescale 1ns / 1ps

package smm_pkg;

  localparam int unsigned NumSegments = 256;
  localparam int unsigned SegWords    = 256;

  localparam int unsigned SegIdW  = 8;
  localparam int unsigned OffW    = 8;
  localparam int unsigned LenW    = 9;
  localparam int unsigned WordW   = 32;
  localparam int unsigned OpW     = 3;
  localparam int unsigned StatW   = 2;
  localparam int unsigned WAddrW  = SegIdW + OffW;
  localparam int unsigned WDepth  = NumSegments * SegWords;

  localparam logic [OpW-1:0] OP_MAP      = 3'd0;
  localparam logic [OpW-1:0] OP_UNMAP    = 3'd1;
  localparam logic [OpW-1:0] OP_LOAD     = 3'd2;
  localparam logic [OpW-1:0] OP_STORE    = 3'd3;
  localparam logic [OpW-1:0] OP_LOADPROG = 3'd4;
  localparam logic [OpW-1:0] OP_APPEND   = 3'd5;

  localparam logic [StatW-1:0] ST_OK       = 2'd0;
  localparam logic [StatW-1:0] ST_NO_ID    = 2'd1;
  localparam logic [StatW-1:0] ST_TOO_LONG = 2'd2;
  localparam logic [StatW-1:0] ST_RANGE    = 2'd3;

  localparam logic [LenW-1:0] MaxLen   = LenW'(SegWords);
  localparam logic [LenW-1:0] MaxCount = LenW'(NumSegments);

endpackage

// ===== sv/smm_ram.sv =====
`timescale 1ns / 1ps

module smm_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== sv/segmented_memory_manager.sv =====
`timescale 1ns / 1ps

// Segmented word memory: 256 segments of up to 256 32-bit words, with map,
// unmap, load, store, load-program and append transactions, one at a time.
// Unmap, load, store, append and every rejected transaction pass from
// acceptance through the execute and done states to the result register,
// and the word and lookup reads happen at the accepting edge. Map adds a
// zero fill of the new segment, one word per cycle through the single
// write port of the word memory; load program from a nonzero segment adds
// the copy of n words, pipelined through that memory's read and write
// ports. A new transaction is accepted as soon as the previous one has
// reached the result register, even while that result still waits to be
// taken. There is no clearing pass after reset; lengths and the free-id
// stack come out of reset at their initial values at once.
module segmented_memory_manager import smm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [OpW-1:0]    op_i,
  input  logic [SegIdW-1:0] segment_i,
  input  logic [OffW-1:0]   word_offset_i,
  input  logic [WordW-1:0]  value_i,
  input  logic [LenW-1:0]   length_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [WordW-1:0]  result_word_o,
  output logic [StatW-1:0]  status_o,
  output logic [LenW-1:0]   segment_length_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_FILL = 3'd2;
  localparam logic [2:0] S_COPY = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [LenW-1:0]   count_q, count_d;
  logic [LenW-1:0]   ptr_q, ptr_d;
  logic              pend_q, pend_d;
  logic              out_valid_q, out_valid_d;

  logic [OpW-1:0]    op_q, op_d;
  logic [SegIdW-1:0] seg_q, seg_d;
  logic [OffW-1:0]   off_q, off_d;
  logic [WordW-1:0]  val_q, val_d;
  logic [LenW-1:0]   len_req_q, len_req_d;
  logic [LenW-1:0]   n_q, n_d;
  logic [SegIdW-1:0] id_q, id_d;
  logic [OffW-1:0]   pend_ptr_q, pend_ptr_d;
  logic [WordW-1:0]  res_q, res_d;
  logic [StatW-1:0]  st_q, st_d;
  logic [LenW-1:0]   sl_q, sl_d;
  logic [WordW-1:0]  out_res_q, out_res_d;
  logic [StatW-1:0]  out_st_q, out_st_d;
  logic [LenW-1:0]   out_sl_q, out_sl_d;

  logic [NumSegments-1:0] len_vld_q;
  logic [NumSegments-1:0] stk_vld_q;

  logic              len_we;
  logic [SegIdW-1:0] len_waddr, len_raddr, len_cur_addr;
  logic [LenW-1:0]   len_wdata, len_rdata, len_cur;
  logic              stk_we;
  logic [SegIdW-1:0] stk_waddr, stk_raddr, stk_idx, stk_wdata, stk_rdata, stk_cur;
  logic              w_we, w_re;
  logic [WAddrW-1:0] w_waddr, w_raddr;
  logic [WordW-1:0]  w_wdata, w_rdata;

  assign in_ready_o       = (state_q == S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign result_word_o    = out_res_q;
  assign status_o         = out_st_q;
  assign segment_length_o = out_sl_q;

  assign len_raddr    = (op_i == OP_APPEND) ? '0 : segment_i;
  assign len_cur_addr = (op_q == OP_APPEND) ? '0 : seg_q;
  assign len_cur      = len_vld_q[len_cur_addr] ? len_rdata : '0;
  assign stk_idx      = SegIdW'(count_q - LenW'(1));
  assign stk_raddr    = stk_idx;
  assign stk_cur      = stk_vld_q[stk_idx] ? stk_rdata : ~stk_idx;

  smm_ram #(.Width(LenW), .Depth(NumSegments)) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (len_we),
    .waddr_i (len_waddr),
    .wdata_i (len_wdata),
    .re_i    (in_valid_i && in_ready_o),
    .raddr_i (len_raddr),
    .rdata_o (len_rdata)
  );

  smm_ram #(.Width(SegIdW), .Depth(NumSegments)) u_stk_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (in_valid_i && in_ready_o),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  smm_ram #(.Width(WordW), .Depth(WDepth)) u_word_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (w_waddr),
    .wdata_i (w_wdata),
    .re_i    (w_re),
    .raddr_i (w_raddr),
    .rdata_o (w_rdata)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    pend_d      = pend_q;
    op_d        = op_q;
    seg_d       = seg_q;
    off_d       = off_q;
    val_d       = val_q;
    len_req_d   = len_req_q;
    n_d         = n_q;
    id_d        = id_q;
    pend_ptr_d  = pend_ptr_q;
    res_d       = res_q;
    st_d        = st_q;
    sl_d        = sl_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_res_d   = out_res_q;
    out_st_d    = out_st_q;
    out_sl_d    = out_sl_q;

    len_we    = 1'b0;
    len_waddr = seg_q;
    len_wdata = len_req_q;
    stk_we    = 1'b0;
    stk_waddr = count_q[SegIdW-1:0];
    stk_wdata = seg_q;
    w_we      = 1'b0;
    w_waddr   = {seg_q, off_q};
    w_wdata   = val_q;
    w_re      = 1'b0;
    w_raddr   = {segment_i, word_offset_i};

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d      = op_i;
          seg_d     = segment_i;
          off_d     = word_offset_i;
          val_d     = value_i;
          len_req_d = length_req_i;
          w_re      = 1'b1;
          state_d   = S_EXEC;
        end
      end
      S_EXEC: begin
        res_d   = '0;
        st_d    = ST_OK;
        sl_d    = '0;
        state_d = S_DONE;
        unique case (op_q) inside
          OP_MAP: begin
            if (len_req_q > MaxLen) begin
              st_d = ST_TOO_LONG;
            end else if (count_q == '0) begin
              st_d = ST_NO_ID;
            end else begin
              count_d   = count_q - LenW'(1);
              id_d      = stk_cur;
              len_we    = 1'b1;
              len_waddr = stk_cur;
              len_wdata = len_req_q;
              res_d     = WordW'(stk_cur);
              sl_d      = len_req_q;
              ptr_d     = '0;
              if (len_req_q != '0) begin
                state_d = S_FILL;
              end
            end
          end
          OP_UNMAP: begin
            if (seg_q == '0) begin
              st_d = ST_RANGE;
            end else begin
              if (count_q < MaxCount) begin
                stk_we  = 1'b1;
                count_d = count_q + LenW'(1);
              end
              sl_d = len_cur;
            end
          end
          OP_LOAD, OP_STORE: begin
            sl_d = len_cur;
            if (LenW'(off_q) >= len_cur) begin
              st_d = ST_RANGE;
            end else if (op_q == OP_LOAD) begin
              res_d = w_rdata;
            end else begin
              w_we = 1'b1;
            end
          end
          OP_LOADPROG: begin
            sl_d = len_cur;
            if (seg_q != '0) begin
              n_d       = len_cur;
              len_we    = 1'b1;
              len_waddr = '0;
              len_wdata = len_cur;
              ptr_d     = '0;
              pend_d    = 1'b0;
              if (len_cur != '0) begin
                state_d = S_COPY;
              end
            end
          end
          OP_APPEND: begin
            sl_d = len_cur;
            if (len_cur >= MaxLen) begin
              st_d = ST_TOO_LONG;
            end else begin
              w_we      = 1'b1;
              w_waddr   = {SegIdW'(0), len_cur[OffW-1:0]};
              w_wdata   = val_q;
              len_we    = 1'b1;
              len_waddr = '0;
              len_wdata = len_cur + LenW'(1);
              sl_d      = len_cur + LenW'(1);
            end
          end
          default: begin
          end
        endcase
      end
      S_FILL: begin
        w_we    = 1'b1;
        w_waddr = {id_q, ptr_q[OffW-1:0]};
        w_wdata = '0;
        ptr_d   = ptr_q + LenW'(1);
        if (ptr_q + LenW'(1) == len_req_q) begin
          state_d = S_DONE;
        end
      end
      S_COPY: begin
        if (ptr_q < n_q) begin
          w_re       = 1'b1;
          w_raddr    = {seg_q, ptr_q[OffW-1:0]};
          ptr_d      = ptr_q + LenW'(1);
          pend_d     = 1'b1;
          pend_ptr_d = ptr_q[OffW-1:0];
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          w_we    = 1'b1;
          w_waddr = {SegIdW'(0), pend_ptr_q};
          w_wdata = w_rdata;
        end
        if (ptr_q == n_q && !pend_q) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_res_d   = res_q;
          out_st_d    = st_q;
          out_sl_d    = sl_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= LenW'(NumSegments - 1);
      ptr_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      len_vld_q   <= '0;
      stk_vld_q   <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (len_we) begin
        len_vld_q[len_waddr] <= 1'b1;
      end
      if (stk_we) begin
        stk_vld_q[stk_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    seg_q      <= seg_d;
    off_q      <= off_d;
    val_q      <= val_d;
    len_req_q  <= len_req_d;
    n_q        <= n_d;
    id_q       <= id_d;
    pend_ptr_q <= pend_ptr_d;
    res_q      <= res_d;
    st_q       <= st_d;
    sl_q       <= sl_d;
    out_res_q  <= out_res_d;
    out_st_q   <= out_st_d;
    out_sl_q   <= out_sl_d;
  end

endmodule

// ===== sv/smm_checker.sv =====
`timescale 1ns / 1ps

module smm_checker import smm_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [WordW-1:0]  result_word_o,
  input logic [StatW-1:0]  status_o,
  input logic [LenW-1:0]   segment_length_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_word_o)
      && $stable(status_o) && $stable(segment_length_o))
    else $error("result changed while stalled");

  a_no_id_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_NO_ID |-> result_word_o == '0 && segment_length_o == '0)
    else $error("failed map carries data");

  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_RANGE |-> result_word_o == '0)
    else $error("out-of-range transaction carries a word");

  a_too_long: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_TOO_LONG |-> result_word_o == '0
      && (segment_length_o == '0 || segment_length_o == MaxLen))
    else $error("too-long transaction carries bad fields");

endmodule

bind segmented_memory_manager smm_checker u_smm_checker (.*);

// ===== tb/segmented_memory_manager_tb.sv =====
`timescale 1ns / 1ps

module segmented_memory_manager_tb;
  import smm_pkg::*;

  localparam logic [OpW-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OpW-1:0] OP_SPARE_HI = 3'd7;

  localparam int MIX_MIXED  = 0;
  localparam int MIX_GROW   = 1;
  localparam int MIX_SHRINK = 2;

  localparam int LONG_HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES    = 300;
  localparam int MAX_PRINTED      = 100;

  typedef struct packed {
    logic [OpW-1:0]    op;
    logic [SegIdW-1:0] seg;
    logic [OffW-1:0]   off;
    logic [WordW-1:0]  value;
    logic [LenW-1:0]   len;
  } seg_request_t;

  typedef struct packed {
    logic [WordW-1:0] word;
    logic [StatW-1:0] status;
    logic [LenW-1:0]  length;
  } seg_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [OpW-1:0]    op_i = OP_MAP;
  logic [SegIdW-1:0] segment_i = '0;
  logic [OffW-1:0]   word_offset_i = '0;
  logic [WordW-1:0]  value_i = '0;
  logic [LenW-1:0]   length_req_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [WordW-1:0]  result_word_o;
  logic [StatW-1:0]  status_o;
  logic [LenW-1:0]   segment_length_o;

  segmented_memory_manager uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .op_i             (op_i),
    .segment_i        (segment_i),
    .word_offset_i    (word_offset_i),
    .value_i          (value_i),
    .length_req_i     (length_req_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .result_word_o    (result_word_o),
    .status_o         (status_o),
    .segment_length_o (segment_length_o)
  );

  // Shadow of the segment memory
  logic [WordW-1:0]  word_mem [WDepth];
  logic [LenW-1:0]   seg_len [NumSegments];
  logic [SegIdW-1:0] free_ids [NumSegments];
  int unsigned       free_count;

  seg_request_t pending_ops[$];
  seg_result_t  awaited_results[$];

  logic in_taken = 1'b0;
  logic calm = 1'b0;
  int   mismatches = 0;
  int   ops_accepted = 0;
  int   results_checked = 0;
  int   status_hits [4] = '{0, 0, 0, 0};
  int   long_holds_req = 0;
  int   long_holds_done = 0;
  int   tx_gap_left = 0;
  int   rx_gap_left = 0;
  int   rx_long_left = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic seg_result_t apply_segment_op(seg_request_t rq);
    seg_result_t r;
    int unsigned id;
    int unsigned n;
    int unsigned k;
    r = '0;
    case (rq.op) inside
      OP_MAP: begin
        if (rq.len > MaxLen) begin
          r.status = ST_TOO_LONG;
        end else if (free_count == 0) begin
          r.status = ST_NO_ID;
        end else begin
          free_count--;
          id = free_ids[free_count];
          seg_len[id] = rq.len;
          for (k = 0; k < rq.len; k++) word_mem[id * SegWords + k] = '0;
          r.word = WordW'(id);
          r.length = rq.len;
        end
      end
      OP_UNMAP: begin
        if (rq.seg == 0) begin
          r.status = ST_RANGE;
        end else begin
          if (free_count < NumSegments) begin
            free_ids[free_count] = rq.seg;
            free_count++;
          end
          r.length = seg_len[rq.seg];
        end
      end
      OP_LOAD, OP_STORE: begin
        r.length = seg_len[rq.seg];
        if (LenW'(rq.off) >= seg_len[rq.seg]) begin
          r.status = ST_RANGE;
        end else if (rq.op == OP_LOAD) begin
          r.word = word_mem[int'(rq.seg) * SegWords + rq.off];
        end else begin
          word_mem[int'(rq.seg) * SegWords + rq.off] = rq.value;
        end
      end
      OP_LOADPROG: begin
        if (rq.seg != 0) begin
          n = seg_len[rq.seg];
          for (k = 0; k < n; k++) word_mem[k] = word_mem[int'(rq.seg) * SegWords + k];
          seg_len[0] = LenW'(n);
        end
        r.length = seg_len[0];
      end
      OP_APPEND: begin
        r.length = seg_len[0];
        if (seg_len[0] >= MaxLen) begin
          r.status = ST_TOO_LONG;
        end else begin
          word_mem[seg_len[0]] = rq.value;
          seg_len[0] = seg_len[0] + 1'b1;
          r.length = seg_len[0];
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic logic [SegIdW-1:0] pick_segment();
    int unsigned live[$];
    int unsigned s;
    for (s = 0; s < NumSegments; s++) if (seg_len[s] != 0) live.push_back(s);
    if (live.size() == 0 || $urandom_range(0, 99) < 15) return SegIdW'($urandom_range(0, 255));
    return SegIdW'(live[$urandom_range(0, live.size() - 1)]);
  endfunction

  function automatic seg_request_t make_request(int mix);
    seg_request_t rq;
    logic [OpW-1:0] ops_rank [6];
    int unsigned cut [6];
    int unsigned sel;
    int unsigned k;
    ops_rank = '{OP_MAP, OP_UNMAP, OP_LOAD, OP_STORE, OP_LOADPROG, OP_APPEND};
    case (mix)
      MIX_GROW:   cut = '{60, 63, 78, 93, 95, 100};
      MIX_SHRINK: cut = '{5, 60, 75, 90, 93, 99};
      default:    cut = '{18, 28, 53, 78, 83, 98};
    endcase
    sel = $urandom_range(0, 99);
    rq.op = ($urandom_range(0, 1) != 0) ? OP_SPARE_HI : OP_SPARE_LO;
    for (k = 6; k > 0; k--) if (sel < cut[k-1]) rq.op = ops_rank[k-1];
    rq.seg = pick_segment();
    if (rq.op == OP_LOADPROG && $urandom_range(0, 4) == 0) rq.seg = '0;
    if (rq.op == OP_UNMAP && mix == MIX_SHRINK && $urandom_range(0, 2) == 0) begin
      rq.seg = SegIdW'($urandom_range(1, 255));
    end
    if (seg_len[rq.seg] != 0 && $urandom_range(0, 99) < 85) begin
      rq.off = OffW'($urandom_range(0, seg_len[rq.seg] - 1));
    end else begin
      rq.off = OffW'($urandom_range(0, 255));
    end
    rq.value = $urandom();
    sel = $urandom_range(0, 99);
    if (sel < 3) rq.len = LenW'($urandom_range(257, 511));
    else if (sel < 6) rq.len = LenW'($urandom_range(200, 256));
    else if (mix == MIX_GROW) rq.len = LenW'($urandom_range(0, 4));
    else rq.len = LenW'($urandom_range(0, 16));
    return rq;
  endfunction

  task automatic add_req(logic [OpW-1:0] op, logic [SegIdW-1:0] seg, logic [OffW-1:0] off,
                         logic [WordW-1:0] value, logic [LenW-1:0] len);
    seg_request_t rq;
    rq.op = op;
    rq.seg = seg;
    rq.off = off;
    rq.value = value;
    rq.len = len;
    pending_ops.push_back(rq);
  endtask

  task automatic feed(int mix, int count);
    int i;
    for (i = 0; i < count; i++) begin
      while (pending_ops.size() >= 2) @(posedge clk_i);
      pending_ops.push_back(make_request(mix));
    end
  endtask

  task automatic wait_for_drain();
    while (pending_ops.size() != 0 || in_valid_i || awaited_results.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  // Driver
  always @(negedge clk_i) begin
    seg_request_t nxt;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (tx_gap_left > 0) begin
        tx_gap_left--;
        in_valid_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        tx_gap_left = $urandom_range(1, 14) - 1;
        in_valid_i <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        nxt = pending_ops.pop_front();
        op_i <= nxt.op;
        segment_i <= nxt.seg;
        word_offset_i <= nxt.off;
        value_i <= nxt.value;
        length_req_i <= nxt.len;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver backpressure
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rx_long_left > 0) begin
        rx_long_left--;
        out_ready_i <= 1'b0;
      end else if (long_holds_req != long_holds_done) begin
        long_holds_done++;
        rx_long_left = LONG_HOLD_CYCLES - 1;
        out_ready_i <= 1'b0;
      end else if (rx_gap_left > 0) begin
        rx_gap_left--;
        out_ready_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        rx_gap_left = $urandom_range(1, 14) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    seg_request_t rq;
    seg_result_t want;
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        rq.op = op_i;
        rq.seg = segment_i;
        rq.off = word_offset_i;
        rq.value = value_i;
        rq.len = length_req_i;
        awaited_results.push_back(apply_segment_op(rq));
        ops_accepted++;
      end
      if (out_valid_o && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result with no transaction outstanding");
        end else begin
          want = awaited_results.pop_front();
          status_hits[want.status]++;
          if (result_word_o !== want.word)
            report_mismatch($sformatf("result %0d: result_word %h, expected %h",
                                      results_checked, result_word_o, want.word));
          if (status_o !== want.status)
            report_mismatch($sformatf("result %0d: status %0d, expected %0d",
                                      results_checked, status_o, want.status));
          if (segment_length_o !== want.length)
            report_mismatch($sformatf("result %0d: segment_length %0d, expected %0d",
                                      results_checked, segment_length_o, want.length));
        end
        results_checked++;
      end
    end
  end

  initial begin
    int k;
    for (k = 0; k < WDepth; k++) word_mem[k] = '0;
    for (k = 0; k < NumSegments; k++) begin
      seg_len[k] = '0;
      free_ids[k] = SegIdW'(NumSegments - 1 - k);
    end
    free_count = NumSegments - 1;

    add_req(OP_UNMAP, 8'd0, 8'd0, 32'h0, 9'd0);
    add_req(OP_UNMAP, 8'd255, 8'd0, 32'h0, 9'd0);
    add_req(OP_UNMAP, 8'd200, 8'd0, 32'h0, 9'd0);
    add_req(OP_MAP, 8'd0, 8'd0, 32'h0, 9'd257);
    add_req(OP_MAP, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 9'h1FF);
    add_req(OP_MAP, 8'd0, 8'd0, 32'h0, 9'd256);
    add_req(OP_MAP, 8'd0, 8'd0, 32'h0, 9'd0);
    add_req(OP_STORE, 8'd255, 8'd255, 32'hFFFF_FFFF, 9'd0);
    add_req(OP_LOAD, 8'd255, 8'd255, 32'h0, 9'd0);
    add_req(OP_LOAD, 8'd255, 8'd0, 32'h0, 9'd0);
    add_req(OP_STORE, 8'd1, 8'd0, 32'h1234_5678, 9'd0);
    add_req(OP_LOAD, 8'd2, 8'd0, 32'h0, 9'd0);
    add_req(OP_APPEND, 8'd0, 8'd0, 32'hA5A5_A5A5, 9'd0);
    add_req(OP_APPEND, 8'd0, 8'd0, 32'hFFFF_FFFF, 9'd0);
    add_req(OP_LOAD, 8'd0, 8'd1, 32'h0, 9'd0);
    add_req(OP_LOADPROG, 8'd0, 8'd0, 32'h0, 9'd0);
    add_req(OP_LOADPROG, 8'd255, 8'd0, 32'h0, 9'd0);
    add_req(OP_APPEND, 8'd0, 8'd0, 32'h5A5A_5A5A, 9'd0);
    add_req(OP_LOAD, 8'd0, 8'd255, 32'h0, 9'd0);
    add_req(OP_MAP, 8'd0, 8'd0, 32'h0, 9'd1);
    add_req(OP_STORE, 8'd2, 8'd0, 32'h8000_0001, 9'd0);
    add_req(OP_LOADPROG, 8'd2, 8'd0, 32'h0, 9'd0);
    add_req(OP_LOAD, 8'd0, 8'd1, 32'h0, 9'd0);
    add_req(OP_SPARE_LO, 8'h5A, 8'hA5, 32'h0F0F_0F0F, 9'h0AA);
    add_req(OP_SPARE_HI, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 9'h1FF);
    add_req(OP_UNMAP, 8'd2, 8'd0, 32'h0, 9'd0);
    add_req(OP_LOAD, 8'd2, 8'd0, 32'h0, 9'd0);
    add_req(OP_MAP, 8'd0, 8'd0, 32'h0, 9'd3);
    add_req(OP_LOAD, 8'd2, 8'd0, 32'h0, 9'd0);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    wait_for_drain();
    feed(MIX_MIXED, 300);
    long_holds_req++;
    feed(MIX_MIXED, 400);
    wait_for_drain();
    feed(MIX_GROW, 150);
    long_holds_req++;
    feed(MIX_GROW, 150);
    feed(MIX_SHRINK, 150);
    wait_for_drain();
    calm = 1'b1;
    feed(MIX_MIXED, 650);
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Ran %0d transactions through map/unmap/load/store/program ops, %0d results checked",
             ops_accepted, results_checked);
    $display("Status mix: ok %0d, no free id %0d, too long %0d, out of range %0d",
             status_hits[ST_OK], status_hits[ST_NO_ID], status_hits[ST_TOO_LONG],
             status_hits[ST_RANGE]);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #(30_000_000);
    $display("Run limit reached with %0d results outstanding", awaited_results.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
